// File: rtl/vlmrq_pkg.sv
`default_nettype none
// ============================================================================
// vlmrq_pkg
// Shared codes and types of the variable-length message ring queue.
// ============================================================================
package vlmrq_pkg;

    // operation selector
    localparam logic [2:0] FN_PUSH_HDR = 3'd0;
    localparam logic [2:0] FN_PUSH_DAT = 3'd1;
    localparam logic [2:0] FN_POP_HDR  = 3'd2;
    localparam logic [2:0] FN_PEEK_HDR = 3'd3;
    localparam logic [2:0] FN_POP_DAT  = 3'd4;

    // result status
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_NOPEND = 2'd3;

    localparam logic [7:0] MAX_DATA_SIZE = 8'd253;
    localparam logic [7:0] HDR_BYTES     = 8'd2;

    localparam logic [3:0] LG_MIN   = 4'd2;
    localparam logic [3:0] LG_MAX   = 4'd8;
    localparam logic [3:0] LG_RESET = 4'd8;

    typedef struct packed {
        logic fits;   // header push has room and a legal size
        logic empty;  // committed pointers equal
    } hdr_chk_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] command;
        logic [7:0] data_size;
        logic [7:0] data;
        logic       last;
        logic       empty;
    } result_t;

endpackage
`default_nettype wire

// File: rtl/vlmrq_hdr_check.sv
`default_nettype none
// ============================================================================
// vlmrq_hdr_check
// Free-space and emptiness check on the committed pointers for header work.
// ============================================================================
module vlmrq_hdr_check #(
    parameter int IDX_W = 8
) (
    input  wire logic [IDX_W-1:0] rp,
    input  wire logic [IDX_W-1:0] wp,
    input  wire logic [IDX_W-1:0] mask,
    input  wire logic [7:0]       size_in,
    output vlmrq_pkg::hdr_chk_t   chk
);
    import vlmrq_pkg::*;

    logic [IDX_W-1:0] room;
    logic [8:0]       need;

    // one slot stays empty so that equal pointers mean an empty ring
    assign room      = (rp - wp - IDX_W'(1)) & mask;
    assign need      = {1'b0, size_in} + {1'b0, HDR_BYTES};
    assign chk.fits  = (size_in <= MAX_DATA_SIZE) && (9'(room) >= need);
    assign chk.empty = (rp == wp);

endmodule
`default_nettype wire

// File: rtl/variable_length_message_ring_queue.sv
`default_nettype none
// ============================================================================
// variable_length_message_ring_queue
// Byte ring holding length-prefixed messages with push, pop and peek.
// ============================================================================
// One transaction a time, all state in a single-port synchronous byte RAM
// plus committed/pending pointers. The one RAM port, with registered read
// data, sets the steps: push data byte (one write) and all rejected or no-op
// requests answer straight from the request; push header writes length, then
// command; pop data byte reads the byte, then answers from the read data; pop
// or peek header reads length, then command. A result waiting on m_tready is
// held in a spare register, so the next request is taken once the current one
// has finished. Writing the ring size register clears both pointers and any
// pending push or pop; the RAM contents are not cleared.
module variable_length_message_ring_queue #(
    parameter int RING_DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: ring_size_log2
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_data,
    // request
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // command_in[7:0], data_size_in[15:8], data_in[23:16]
    input  wire logic [2:0]  s_tuser,  // func[2:0]
    // result
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // command_out[7:0], data_size_out[15:8],
                                       // data_out[23:16], empty_res[24], zero[31:25]
    output logic [1:0]       m_tuser,  // status[1:0]
    output logic             m_tlast   // last_byte
);
    import vlmrq_pkg::*;

    localparam int IDX_W = $clog2(RING_DEPTH);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_PUSH_CMD = 3'd1;
    localparam logic [2:0] S_HDR_LEN  = 3'd2;
    localparam logic [2:0] S_HDR_CMD  = 3'd3;
    localparam logic [2:0] S_POP_DAT  = 3'd4;
    localparam logic [2:0] S_WAIT_OUT = 3'd5;

    logic [7:0] ring_mem [RING_DEPTH];
    logic [7:0] mem_q;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_addr;
    logic [7:0]        mem_wdata;

    logic [2:0] state_reg, state_next;
    logic [3:0] lg_reg, lg_next;
    logic [IDX_W-1:0] rp_reg, rp_next, wp_reg, wp_next;
    logic [IDX_W-1:0] push_cur_reg, push_cur_next, pop_cur_reg, pop_cur_next;
    logic [7:0]       push_rem_reg, push_rem_next, pop_rem_reg, pop_rem_next;
    logic [IDX_W-1:0] addr_hold_reg, addr_hold_next;
    logic [2:0]       func_reg, func_next;
    logic [7:0]       cmd_reg, cmd_next, len_reg, len_next;
    result_t          hold_reg, hold_next, out_reg, out_next;
    logic             m_tvalid_reg, m_tvalid_next;

    logic [2:0] s_func;
    logic [7:0] cmd_in, size_in, byte_in;
    logic       in_fire, out_free, res_valid;
    result_t    res;
    logic [3:0] lg_c;
    logic [7:0] mask8;
    logic [IDX_W-1:0] mask;
    hdr_chk_t   chk;

    assign s_func  = s_tuser;
    assign cmd_in  = s_tdata[7:0];
    assign size_in = s_tdata[15:8];
    assign byte_in = s_tdata[23:16];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        lg_c = lg_reg;
        if (lg_reg < LG_MIN) begin
            lg_c = LG_MIN;
        end else if (lg_reg > LG_MAX) begin
            lg_c = LG_MAX;
        end
    end

    assign mask8 = 8'((9'd1 << lg_c) - 9'd1);
    assign mask  = mask8[IDX_W-1:0];

    vlmrq_hdr_check #(
        .IDX_W (IDX_W)
    ) u_hdr_check (
        .rp      (rp_reg),
        .wp      (wp_reg),
        .mask    (mask),
        .size_in (size_in),
        .chk     (chk)
    );

    // single-port ring RAM, read data registered
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[mem_addr] <= mem_wdata;
        end
        mem_q <= ring_mem[mem_addr];
    end

    always_comb begin
        logic [7:0] dsz;
        dsz            = len_reg - HDR_BYTES;
        state_next     = state_reg;
        lg_next        = lg_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        push_cur_next  = push_cur_reg;
        push_rem_next  = push_rem_reg;
        pop_cur_next   = pop_cur_reg;
        pop_rem_next   = pop_rem_reg;
        addr_hold_next = addr_hold_reg;
        func_next      = func_reg;
        cmd_next       = cmd_reg;
        len_next       = len_reg;
        hold_next      = hold_reg;
        out_next       = out_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        mem_we         = 1'b0;
        mem_addr       = rp_reg;
        mem_wdata      = byte_in;
        res            = '0;
        res_valid      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    func_next = s_func;
                    cmd_next  = cmd_in;
                    unique case (s_func)
                        FN_PUSH_HDR: begin
                            if (!chk.fits) begin
                                res_valid  = 1'b1;
                                res.status = ST_FULL;
                            end else begin
                                mem_we         = 1'b1;
                                mem_addr       = wp_reg;
                                mem_wdata      = size_in + HDR_BYTES;
                                addr_hold_next = (wp_reg + IDX_W'(1)) & mask;
                                push_cur_next  = (wp_reg + IDX_W'(2)) & mask;
                                push_rem_next  = size_in;
                                if (size_in == 8'd0) begin
                                    wp_next = (wp_reg + IDX_W'(2)) & mask;
                                end
                                state_next = S_PUSH_CMD;
                            end
                        end
                        FN_PUSH_DAT: begin
                            res_valid = 1'b1;
                            if (push_rem_reg == 8'd0) begin
                                res.status = ST_NOPEND;
                            end else begin
                                mem_we        = 1'b1;
                                mem_addr      = push_cur_reg;
                                push_cur_next = (push_cur_reg + IDX_W'(1)) & mask;
                                push_rem_next = push_rem_reg - 8'd1;
                                // commit the message at its last byte
                                if (push_rem_reg == 8'd1) begin
                                    wp_next = (push_cur_reg + IDX_W'(1)) & mask;
                                end
                            end
                        end
                        FN_POP_HDR, FN_PEEK_HDR: begin
                            if (chk.empty) begin
                                res_valid  = 1'b1;
                                res.status = ST_EMPTY;
                            end else begin
                                state_next = S_HDR_LEN;
                            end
                        end
                        FN_POP_DAT: begin
                            if (pop_rem_reg == 8'd0) begin
                                res_valid  = 1'b1;
                                res.status = ST_NOPEND;
                            end else begin
                                mem_addr     = pop_cur_reg;
                                pop_cur_next = (pop_cur_reg + IDX_W'(1)) & mask;
                                pop_rem_next = pop_rem_reg - 8'd1;
                                if (pop_rem_reg == 8'd1) begin
                                    rp_next = (pop_cur_reg + IDX_W'(1)) & mask;
                                end
                                state_next = S_POP_DAT;
                            end
                        end
                        default: begin
                            res_valid  = 1'b1;
                            res.status = ST_NOPEND;
                        end
                    endcase
                end
            end
            S_PUSH_CMD: begin
                mem_we    = 1'b1;
                mem_addr  = addr_hold_reg;
                mem_wdata = cmd_reg;
                res_valid = 1'b1;
            end
            S_HDR_LEN: begin
                len_next   = mem_q;
                mem_addr   = (rp_reg + IDX_W'(1)) & mask;
                state_next = S_HDR_CMD;
            end
            S_HDR_CMD: begin
                res_valid     = 1'b1;
                res.command   = mem_q;
                res.data_size = dsz;
                if (dsz == 8'd0) begin
                    // a message without data goes on pop and on peek alike
                    rp_next = (rp_reg + IDX_W'(2)) & mask;
                    if (func_reg == FN_POP_HDR) begin
                        pop_rem_next = 8'd0;
                    end
                end else if (func_reg == FN_POP_HDR) begin
                    pop_cur_next = (rp_reg + IDX_W'(2)) & mask;
                    pop_rem_next = dsz;
                end
            end
            S_POP_DAT: begin
                res_valid = 1'b1;
                res.data  = mem_q;
                res.last  = (pop_rem_reg == 8'd0);
            end
            S_WAIT_OUT: begin
                if (out_free) begin
                    out_next      = hold_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        res.empty = (rp_next == wp_next);

        if (res_valid) begin
            if (out_free) begin
                out_next      = res;
                m_tvalid_next = 1'b1;
                state_next    = S_IDLE;
            end else begin
                hold_next  = res;
                state_next = S_WAIT_OUT;
            end
        end

        // size change re-initialises the queue
        if (cfg_valid && cfg_ready) begin
            lg_next       = cfg_data;
            rp_next       = '0;
            wp_next       = '0;
            push_cur_next = '0;
            push_rem_next = 8'd0;
            pop_cur_next  = '0;
            pop_rem_next  = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            lg_reg       <= LG_RESET;
            rp_reg       <= '0;
            wp_reg       <= '0;
            push_cur_reg <= '0;
            push_rem_reg <= 8'd0;
            pop_cur_reg  <= '0;
            pop_rem_reg  <= 8'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            lg_reg       <= lg_next;
            rp_reg       <= rp_next;
            wp_reg       <= wp_next;
            push_cur_reg <= push_cur_next;
            push_rem_reg <= push_rem_next;
            pop_cur_reg  <= pop_cur_next;
            pop_rem_reg  <= pop_rem_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_hold_reg <= addr_hold_next;
        func_reg      <= func_next;
        cmd_reg       <= cmd_next;
        len_reg       <= len_next;
        hold_reg      <= hold_next;
        out_reg       <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_reg.empty, out_reg.data, out_reg.data_size, out_reg.command};
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;

    // no RAM write while a read sequence is in flight
    a_no_write_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_HDR_LEN || state_reg == S_HDR_CMD || state_reg == S_POP_DAT)
        |-> !mem_we)
        else $error("ring RAM written during a read sequence");

    a_push_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        push_rem_reg <= MAX_DATA_SIZE)
        else $error("pending push count out of range");

    a_stalled_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && m_tvalid_reg && !m_tready) |=> (state_reg == S_WAIT_OUT))
        else $error("result lost while output stalled");

    a_ptr_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        ((rp_reg & ~mask) == '0) && ((wp_reg & ~mask) == '0))
        else $error("committed pointer outside ring size");

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the variable-length message ring queue.
// ============================================================================
// A short table of directed requests runs first at the reset ring size: empty
// and no-pending answers, rejected sizes, zero-length messages, an abandoned
// push, and a peek and a restart during a pop. Then several ring sizes are
// programmed, the clamped extremes among them. Each setting gets random
// message traffic: whole pushes and pops with random content, cut-short
// sequences and stray requests. Every accepted request is run through a
// local model of the ring. Each result is compared field by field with the
// oldest expectation.
module tb_top;
    import vlmrq_pkg::*;

    typedef struct {
        logic [2:0] fn;
        logic [7:0] cmd;
        logic [7:0] size;
        logic [7:0] din;
        logic       known;   // expected result typed in below
        result_t    want;
    } stim_row_t;

    localparam int DIR_ROWS = 25;
    localparam int PHASES   = 7;
    localparam int PHASE_ITEMS = 110;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // command_in[7:0], data_size_in[15:8], data_in[23:16]
    logic [2:0]  s_tuser   = '0;   // func[2:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // command_out[7:0], data_size_out[15:8],
                                   // data_out[23:16], empty_res[24]
    logic [1:0]  m_tuser;          // status[1:0]
    logic        m_tlast;          // last_byte

    // ring model state
    logic [7:0] ring_bytes [0:255];
    logic [3:0] ring_lg   = LG_RESET;
    logic [7:0] rd_ptr    = '0;
    logic [7:0] wr_ptr    = '0;
    logic [7:0] push_cur  = '0;
    logic [7:0] push_left = '0;
    logic [7:0] pop_cur   = '0;
    logic [7:0] pop_left  = '0;

    result_t expected_results [$];
    result_t want;
    int      mismatches    = 0;
    int      results_seen  = 0;
    int      requests_sent = 0;
    int      requests_taken = 0;
    logic    quiet = 1'b0;

    stim_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{FN_POP_DAT,  8'h00, 8'h00, 8'h00, 1'b1, '{ST_NOPEND, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
        '{FN_POP_HDR,  8'h00, 8'h00, 8'h00, 1'b1, '{ST_EMPTY,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
        '{FN_PEEK_HDR, 8'h00, 8'h00, 8'h00, 1'b1, '{ST_EMPTY,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
        '{FN_PUSH_DAT, 8'h00, 8'h00, 8'hFF, 1'b1, '{ST_NOPEND, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
        '{3'd5,        8'h00, 8'h00, 8'h00, 1'b1, '{ST_NOPEND, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
        '{3'd6,        8'hFF, 8'hFF, 8'hFF, 1'b1, '{ST_NOPEND, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
        '{3'd7,        8'h00, 8'h00, 8'h00, 1'b1, '{ST_NOPEND, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
        // oversized messages
        '{FN_PUSH_HDR, 8'h11, 8'd254, 8'h00, 1'b1, '{ST_FULL,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
        '{FN_PUSH_HDR, 8'h22, 8'd255, 8'h00, 1'b1, '{ST_FULL,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
        // zero-length messages commit at once and leave on peek or pop
        '{FN_PUSH_HDR, 8'hFF, 8'd0, 8'h00, 1'b1, '{ST_OK,     8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
        '{FN_PEEK_HDR, 8'h00, 8'd0, 8'h00, 1'b1, '{ST_OK,     8'hFF, 8'h00, 8'h00, 1'b0, 1'b1}},
        '{FN_PUSH_HDR, 8'h3C, 8'd0, 8'h00, 1'b1, '{ST_OK,     8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
        '{FN_POP_HDR,  8'h00, 8'd0, 8'h00, 1'b1, '{ST_OK,     8'h3C, 8'h00, 8'h00, 1'b0, 1'b1}},
        '{FN_POP_DAT,  8'h00, 8'd0, 8'h00, 1'b1, '{ST_NOPEND, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
        // a new header abandons the half-written message
        '{FN_PUSH_HDR, 8'h00, 8'd2, 8'h00, 1'b1, '{ST_OK,     8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
        '{FN_PUSH_DAT, 8'h00, 8'd0, 8'hFF, 1'b1, '{ST_OK,     8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
        '{FN_PUSH_HDR, 8'hA5, 8'd1, 8'h00, 1'b1, '{ST_OK,     8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
        '{FN_PUSH_DAT, 8'h00, 8'd0, 8'h00, 1'b1, '{ST_OK,     8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
        '{FN_PUSH_DAT, 8'h00, 8'd0, 8'h77, 1'b1, '{ST_NOPEND, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
        // peek, pop, peek during the pop, restart, then the data byte
        '{FN_PEEK_HDR, 8'h00, 8'd0, 8'h00, 1'b0, '0},
        '{FN_POP_HDR,  8'h00, 8'd0, 8'h00, 1'b0, '0},
        '{FN_PEEK_HDR, 8'h00, 8'd0, 8'h00, 1'b0, '0},
        '{FN_POP_HDR,  8'h00, 8'd0, 8'h00, 1'b0, '0},
        '{FN_POP_DAT,  8'h00, 8'd0, 8'h00, 1'b0, '0},
        '{FN_PUSH_HDR, 8'h5A, 8'd253, 8'h00, 1'b0, '0}
    };

    logic [3:0] ring_settings [0:PHASES-1] = '{4'd0, 4'd2, 4'd15, 4'd8, 4'd3, 4'd5, 4'd4};

    variable_length_message_ring_queue DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [7:0] ring_mask();
        logic [3:0] lg;
        logic [8:0] m;
        lg = ring_lg;
        if (lg < LG_MIN) lg = LG_MIN;
        if (lg > LG_MAX) lg = LG_MAX;
        m = (9'd1 << lg) - 9'd1;
        return m[7:0];
    endfunction

    // Advance the ring model by one request and return its answer.
    function automatic result_t predict_ring_step(input logic [2:0] fn, input logic [7:0] cmd,
                                                  input logic [7:0] size, input logic [7:0] din);
        result_t    r;
        logic [7:0] mask;
        logic [7:0] rp;
        logic [7:0] wp;
        logic [7:0] room;
        logic [7:0] dsz;
        logic [7:0] pc;
        logic [8:0] need;
        r    = '0;
        mask = ring_mask();
        rp   = rd_ptr & mask;
        wp   = wr_ptr & mask;
        case (fn)
            FN_PUSH_HDR: begin
                need = {1'b0, size} + 9'd2;
                room = (rp - wp - 8'd1) & mask;
                if (size > MAX_DATA_SIZE || {1'b0, room} < need) begin
                    r.status = ST_FULL;
                end else begin
                    ring_bytes[wp] = need[7:0];
                    ring_bytes[(wp + 8'd1) & mask] = cmd;
                    push_cur  = (wp + 8'd2) & mask;
                    push_left = size;
                    if (size == 8'd0) wr_ptr = push_cur;
                end
            end
            FN_PUSH_DAT: begin
                if (push_left == 8'd0) begin
                    r.status = ST_NOPEND;
                end else begin
                    pc = push_cur & mask;
                    ring_bytes[pc] = din;
                    push_cur  = (pc + 8'd1) & mask;
                    push_left = push_left - 8'd1;
                    if (push_left == 8'd0) wr_ptr = push_cur;
                end
            end
            FN_POP_HDR, FN_PEEK_HDR: begin
                if (rp == wp) begin
                    r.status = ST_EMPTY;
                end else begin
                    dsz = ring_bytes[rp] - HDR_BYTES;
                    r.command   = ring_bytes[(rp + 8'd1) & mask];
                    r.data_size = dsz;
                    if (dsz == 8'd0) begin
                        rd_ptr = (rp + 8'd2) & mask;
                        if (fn == FN_POP_HDR) pop_left = 8'd0;
                    end else if (fn == FN_POP_HDR) begin
                        pop_cur  = (rp + 8'd2) & mask;
                        pop_left = dsz;
                    end
                end
            end
            FN_POP_DAT: begin
                if (pop_left == 8'd0) begin
                    r.status = ST_NOPEND;
                end else begin
                    pc = pop_cur & mask;
                    r.data   = ring_bytes[pc];
                    pop_cur  = (pc + 8'd1) & mask;
                    pop_left = pop_left - 8'd1;
                    if (pop_left == 8'd0) begin
                        r.last = 1'b1;
                        rd_ptr = pop_cur;
                    end
                end
            end
            default: r.status = ST_NOPEND;
        endcase
        r.empty = ((rd_ptr & mask) == (wr_ptr & mask));
        return r;
    endfunction

    // Called at a rising edge; returns at the edge that accepts the transaction.
    task automatic send_request(input logic [2:0] fn, input logic [7:0] cmd,
                                input logic [7:0] size, input logic [7:0] din,
                                input logic known, input result_t typed_want,
                                output result_t predicted);
        if (!quiet && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {din, size, cmd};
        do @(posedge aclk); while (!s_tready);
        predicted = predict_ring_step(fn, cmd, size, din);
        expected_results.push_back(known ? typed_want : predicted);
        requests_sent++;
        if (predicted.status != ST_NOPEND) requests_taken++;
    endtask

    task automatic apply_ring_size(input logic [3:0] lg);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= lg;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        ring_lg   = lg;
        rd_ptr    = '0;
        wr_ptr    = '0;
        push_cur  = '0;
        push_left = '0;
        pop_cur   = '0;
        pop_left  = '0;
    endtask

    task automatic check_field(input string what, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= quiet || ($urandom_range(99) >= 6);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing expected, status %0h data %0h",
                         $time, m_tuser, m_tdata);
            end else begin
                want = expected_results.pop_front();
                results_seen++;
                check_field("status",    {6'd0, want.status}, {6'd0, m_tuser});
                check_field("command",   want.command,        m_tdata[7:0]);
                check_field("data_size", want.data_size,      m_tdata[15:8]);
                check_field("data",      want.data,           m_tdata[23:16]);
                check_field("last_byte", {7'd0, want.last},   {7'd0, m_tlast});
                check_field("empty",     {7'd0, want.empty},  {7'd0, m_tdata[24]});
            end
        end
    end

    initial begin : stimulus
        result_t    got;
        logic [7:0] mask;
        logic [7:0] size;
        int         pick;
        int         n;
        int         start;
        foreach (ring_bytes[i]) ring_bytes[i] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_request(dir_rows[i].fn, dir_rows[i].cmd, dir_rows[i].size, dir_rows[i].din,
                         dir_rows[i].known, dir_rows[i].want, got);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            apply_ring_size(ring_settings[ph]);
            quiet <= (ph == 3);
            mask  = ring_mask();
            start = requests_taken;
            while (requests_taken - start < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    // whole message push, sometimes cut short or oversized
                    n = $urandom_range(99);
                    if (n < 75)      size = 8'($urandom_range(0, (mask < 8'd12) ? mask : 12));
                    else if (n < 92) size = 8'($urandom_range(0, mask + 2));
                    else             size = 8'($urandom_range(0, 255));
                    send_request(FN_PUSH_HDR, 8'($urandom_range(0, 255)), size,
                                 8'($urandom_range(0, 255)), 1'b0, '0, got);
                    if (got.status == ST_OK) begin
                        n = ($urandom_range(99) < 10) ? int'($urandom_range(0, size))
                                                      : int'(size);
                    end else begin
                        n = ($urandom_range(99) < 30) ? 1 : 0;
                    end
                    repeat (n) send_request(FN_PUSH_DAT, 8'($urandom_range(0, 255)),
                                            8'($urandom_range(0, 255)),
                                            8'($urandom_range(0, 255)),
                                            1'b0, '0, got);
                end else if (pick < 75) begin
                    // whole message pop, sometimes cut short or overrun
                    send_request(FN_POP_HDR, 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 1'b0, '0, got);
                    n = int'(got.data_size);
                    if ($urandom_range(99) < 10) n = int'($urandom_range(0, n));
                    else if ($urandom_range(99) < 5) n = n + 1;
                    for (int k = 0; k < n; k++) begin
                        if ($urandom_range(99) < 5) begin
                            send_request(FN_PEEK_HDR, 8'h00, 8'h00, 8'h00, 1'b0, '0, got);
                        end
                        send_request(FN_POP_DAT, 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)), 1'b0, '0, got);
                    end
                end else if (pick < 85) begin
                    send_request(FN_PEEK_HDR, 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 1'b0, '0, got);
                end else if (pick < 93) begin
                    send_request(($urandom_range(1) != 0) ? FN_PUSH_DAT : FN_POP_DAT,
                                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 1'b0, '0, got);
                end else begin
                    send_request(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 1'b0, '0, got);
                end
            end
        end

        // drain, then let the block settle
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("Sent %0d requests over %0d ring-size settings; %0d results checked.",
                 requests_sent, PHASES + 1, results_seen);
        $display("Mix covered push, pop, peek, rejects, abandoned pushes and stray requests.");
        if (mismatches == 0) begin
            $display("[variable_length_message_ring_queue] OK");
        end else begin
            $display("[variable_length_message_ring_queue] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
        $display("[variable_length_message_ring_queue] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
rtl/vlmrq_pkg.sv
rtl/vlmrq_hdr_check.sv
rtl/variable_length_message_ring_queue.sv
tb/sv/tb_top.sv
